// ===== rtl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_NUM    = 2'd0;
   localparam cmd_type CMD_LPAREN = 2'd1;
   localparam cmd_type CMD_RPAREN = 2'd2;
   localparam cmd_type CMD_OP     = 2'd3;

   typedef logic [3:0] op_type;
   localparam op_type OP_MUL   = 4'd0;
   localparam op_type OP_DIV   = 4'd1;
   localparam op_type OP_MOD   = 4'd2;
   localparam op_type OP_ADD   = 4'd3;
   localparam op_type OP_SUB   = 4'd4;
   localparam op_type OP_LT    = 4'd5;
   localparam op_type OP_LE    = 4'd6;
   localparam op_type OP_GT    = 4'd7;
   localparam op_type OP_GE    = 4'd8;
   localparam op_type OP_NE    = 4'd9;
   localparam op_type OP_EQ    = 4'd10;
   localparam op_type OP_NOT   = 4'd11;
   localparam op_type OP_AND   = 4'd12;
   localparam op_type OP_OR    = 4'd13;
   localparam op_type OP_PAREN = 4'd14;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK    = 3'd0;
   localparam status_type ST_UNDER = 3'd1;
   localparam status_type ST_PAREN = 3'd2;
   localparam status_type ST_NOT   = 3'd3;
   localparam status_type ST_DIVZ  = 3'd4;
   localparam status_type ST_OVER  = 3'd5;
   localparam status_type ST_LEFT  = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE, S_TOKEN, S_OPRD, S_OPCHK, S_V1, S_V2, S_V3, S_EXEC, S_DIVW, S_FIN, S_OUT
   } state_type;

   typedef struct packed {
      logic                   start;
      logic                   is_mod;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [VALUE_WIDTH-1:0] result;
   } div_rsp_type;

   function automatic logic [2:0] prec_of(op_type op);
      logic [2:0] p;
      if (op <= OP_MOD) p = 3'd5;
      else if (op <= OP_SUB) p = 3'd4;
      else if (op <= OP_EQ) p = 3'd3;
      else if (op == OP_NOT) p = 3'd2;
      else if (op == OP_AND) p = 3'd1;
      else p = 3'd0;
      return p;
   endfunction

endpackage

// ===== rtl/iee_divider.sv =====
// ----------------------------------------------------------------------------
// iee_divider
// Radix-2 restoring divider, signed truncating quotient or remainder.
// ----------------------------------------------------------------------------
module iee_divider
   import iee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int W = VALUE_WIDTH;
   localparam int SW = $clog2(W + 1);

   logic [W-1:0] quo_ff, quo_in;
   logic [W:0]   rem_ff, rem_in;
   logic [W-1:0] dsr_ff, dsr_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic qneg_ff, qneg_in, rneg_ff, rneg_in, mod_ff, mod_in;
   logic [W:0] trial;
   logic [W-1:0] mag_q, mag_r;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dsr_in = dsr_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      qneg_in = qneg_ff; rneg_in = rneg_ff; mod_in = mod_ff;
      trial = {rem_ff[W-1:0], quo_ff[W-1]} - {1'b0, dsr_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = SW'(W);
         mod_in = req.is_mod;
         qneg_in = req.dividend[W-1] ^ req.divisor[W-1];
         rneg_in = req.dividend[W-1];
         quo_in = req.dividend[W-1] ? -req.dividend : req.dividend;
         dsr_in = req.divisor[W-1] ? -req.divisor : req.divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-1:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dsr_ff <= dsr_in; cnt_ff <= cnt_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in; mod_ff <= mod_in;
   end

   assign mag_q = qneg_ff ? -quo_ff : quo_ff;
   assign mag_r = rneg_ff ? -rem_ff[W-1:0] : rem_ff[W-1:0];
   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.result = mod_ff ? mag_r : mag_q;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("divider restarted while busy");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
`endif

endmodule

// ===== rtl/iee_stacks.sv =====
// ----------------------------------------------------------------------------
// iee_stacks
// Value and operator stack memories with registered read data.
// ----------------------------------------------------------------------------
module iee_stacks
   import iee_pkg::*;
(
   input  logic                   clock,
   input  logic                   v_we,
   input  logic [PTR_W-1:0]       v_waddr,
   input  logic [VALUE_WIDTH-1:0] v_wdata,
   input  logic [PTR_W-1:0]       v_raddr,
   output logic [VALUE_WIDTH-1:0] v_rdata,
   input  logic                   o_we,
   input  logic [PTR_W-1:0]       o_waddr,
   input  op_type                 o_wdata,
   input  logic [PTR_W-1:0]       o_raddr,
   output op_type                 o_rdata
);

   logic [VALUE_WIDTH-1:0] vmem [STACK_DEPTH];
   op_type                 omem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (v_we) vmem[v_waddr] <= v_wdata;
      v_rdata <= vmem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (o_we) omem[o_waddr] <= o_wdata;
      o_rdata <= omem[o_raddr];
   end

endmodule

// ===== rtl/infix_expression_evaluator_core.sv =====
// Flow: a number or left paren passes S_TOKEN and S_FIN, or only S_FIN once an
// error is latched; each applied operator runs S_V1, S_V2, S_V3 and S_EXEC,
// and div and mod also wait in S_DIVW on the radix-2 divider. The last token
// drains the operator stack one operator at a time; S_OUT loads the result.
// One transaction is in work at a time; the result sits in an output register.
// Synchronous active-high reset empties both stacks and clears the error latch.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Shunting-yard evaluator over stack memories with a shared iterative divider.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core
   import iee_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_op_code,
   input  logic signed [31:0] req_number,
   input  logic               req_last_token,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_answer,
   output logic [2:0]         rsp_status
);

   localparam int W = VALUE_WIDTH;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] vcnt_ff, vcnt_in, ocnt_ff, ocnt_in;
   status_type err_ff, err_in;
   cmd_type cmd_ff, cmd_in;
   op_type tok_ff, tok_in, cur_ff, cur_in;
   logic [W-1:0] num_ff, num_in, x_ff, x_in, y_ff, y_in;
   logic last_ff, last_in;
   logic ovalid_ff, ovalid_in;
   logic [31:0] oans_ff, oans_in;
   status_type ost_ff, ost_in;

   logic v_we, o_we;
   logic [PTR_W-1:0] v_waddr, v_raddr, o_waddr, o_raddr;
   logic [W-1:0] v_wdata, v_rdata;
   op_type o_wdata, o_rdata;
   div_req_type dreq;
   div_rsp_type drsp;

   logic [2*W-1:0] prod;
   logic [W:0] sum, dif;
   logic signed [W-1:0] sx, sy;
   logic [W-1:0] vmin;

   iee_stacks u_stacks (
      .clock, .v_we, .v_waddr, .v_wdata, .v_raddr, .v_rdata,
      .o_we, .o_waddr, .o_wdata, .o_raddr, .o_rdata
   );

   iee_divider u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   assign sx = x_ff;
   assign sy = y_ff;
   assign vmin = {1'b1, {(W-1){1'b0}}};

   always_comb begin
      prod = (2*W)'(sx * sy);
      sum = {sx[W-1], sx} + {sy[W-1], sy};
      dif = {sx[W-1], sx} - {sy[W-1], sy};
   end

   always_comb begin
      state_in = state_ff; vcnt_in = vcnt_ff; ocnt_in = ocnt_ff; err_in = err_ff;
      cmd_in = cmd_ff; tok_in = tok_ff; cur_in = cur_ff; num_in = num_ff;
      x_in = x_ff; y_in = y_ff; last_in = last_ff;
      ovalid_in = ovalid_ff; oans_in = oans_ff; ost_in = ost_ff;
      v_we = 1'b0; v_waddr = vcnt_ff[PTR_W-1:0]; v_wdata = num_ff;
      v_raddr = vcnt_ff[PTR_W-1:0] - 1'b1;
      o_we = 1'b0; o_waddr = ocnt_ff[PTR_W-1:0]; o_wdata = tok_ff;
      o_raddr = ocnt_ff[PTR_W-1:0] - 1'b1;
      dreq = '0;
      dreq.dividend = x_ff; dreq.divisor = y_ff; dreq.is_mod = (cur_ff == OP_MOD);
      req_ready = 1'b0;
      if (ovalid_ff && rsp_ready) ovalid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !ovalid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd_in = req_command; tok_in = req_op_code; num_in = req_number;
               last_in = req_last_token;
               state_in = (err_ff != ST_OK) ? S_FIN : S_TOKEN;
            end
         end
         S_TOKEN: begin
            unique case (cmd_ff)
               CMD_NUM: begin
                  if (vcnt_ff >= CNT_W'(STACK_DEPTH)) err_in = ST_OVER;
                  else begin
                     v_we = 1'b1; vcnt_in = vcnt_ff + 1'b1;
                  end
                  state_in = S_FIN;
               end
               CMD_LPAREN: begin
                  if (ocnt_ff >= CNT_W'(STACK_DEPTH)) err_in = ST_OVER;
                  else begin
                     o_we = 1'b1; o_wdata = OP_PAREN; ocnt_in = ocnt_ff + 1'b1;
                  end
                  state_in = S_FIN;
               end
               CMD_RPAREN: begin
                  if (ocnt_ff == '0) begin
                     err_in = ST_PAREN; state_in = S_FIN;
                  end else state_in = S_OPRD;
               end
               default: begin
                  if (tok_ff > OP_OR) state_in = S_FIN;
                  else if (tok_ff == OP_NOT || ocnt_ff == '0) state_in = S_OPCHK;
                  else state_in = S_OPRD;
               end
            endcase
         end
         S_OPRD: begin
            state_in = S_OPCHK;
         end
         S_OPCHK: begin
            // o_rdata holds top of operator stack when reached from S_OPRD
            state_in = S_FIN;
            if (cmd_ff == CMD_RPAREN) begin
               ocnt_in = ocnt_ff - 1'b1;
               if (o_rdata != OP_PAREN) begin
                  cur_in = o_rdata; state_in = S_V1;
               end
            end else if (tok_ff != OP_PAREN) begin
               if (tok_ff != OP_NOT && ocnt_ff != '0 && o_rdata != OP_PAREN
                   && prec_of(o_rdata) >= prec_of(tok_ff)) begin
                  ocnt_in = ocnt_ff - 1'b1;
                  cur_in = o_rdata; state_in = S_V1;
               end else if (ocnt_ff >= CNT_W'(STACK_DEPTH)) begin
                  err_in = ST_OVER;
               end else begin
                  o_we = 1'b1; ocnt_in = ocnt_ff + 1'b1;
               end
            end else begin
               // drain at last token
               ocnt_in = ocnt_ff - 1'b1;
               if (o_rdata == OP_PAREN) err_in = ST_PAREN;
               else begin
                  cur_in = o_rdata; state_in = S_V1;
               end
            end
         end
         S_V1: begin
            v_raddr = vcnt_ff[PTR_W-1:0] - 1'b1;
            if (cur_ff == OP_NOT ? vcnt_ff == '0 : vcnt_ff < CNT_W'(2)) begin
               err_in = ST_UNDER; state_in = S_FIN;
            end else state_in = S_V2;
         end
         S_V2: begin
            y_in = v_rdata;
            v_raddr = vcnt_ff[PTR_W-1:0] - 2'd2;
            state_in = S_V3;
         end
         S_V3: begin
            x_in = v_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIN;
            if (cur_ff == OP_NOT) begin
               v_waddr = vcnt_ff[PTR_W-1:0] - 1'b1;
               if (y_ff == W'(0)) begin
                  v_we = 1'b1; v_wdata = W'(1);
               end else if (y_ff == W'(1)) begin
                  v_we = 1'b1; v_wdata = '0;
               end else err_in = ST_NOT;
            end else begin
               v_waddr = vcnt_ff[PTR_W-1:0] - 2'd2;
               v_wdata = '0;
               v_we = 1'b1;
               vcnt_in = vcnt_ff - 1'b1;
               case (cur_ff)
                  OP_MUL: begin
                     v_wdata = prod[W-1:0];
                     if (prod[2*W-1:W-1] != {(W+1){prod[W-1]}}) begin
                        err_in = ST_OVER; v_we = 1'b0;
                     end
                  end
                  OP_DIV, OP_MOD: begin
                     v_we = 1'b0;
                     if (y_ff == '0) err_in = ST_DIVZ;
                     else if (cur_ff == OP_DIV && x_ff == vmin && y_ff == '1)
                        err_in = ST_OVER;
                     else begin
                        dreq.start = 1'b1; state_in = S_DIVW;
                     end
                  end
                  OP_ADD: begin
                     v_wdata = sum[W-1:0];
                     if (sum[W] != sum[W-1]) begin
                        err_in = ST_OVER; v_we = 1'b0;
                     end
                  end
                  OP_SUB: begin
                     v_wdata = dif[W-1:0];
                     if (dif[W] != dif[W-1]) begin
                        err_in = ST_OVER; v_we = 1'b0;
                     end
                  end
                  OP_LT: v_wdata = W'(sx < sy);
                  OP_LE: v_wdata = W'(sx <= sy);
                  OP_GT: v_wdata = W'(sx > sy);
                  OP_GE: v_wdata = W'(sx >= sy);
                  OP_NE: v_wdata = W'(sx != sy);
                  OP_EQ: v_wdata = W'(sx == sy);
                  OP_AND: v_wdata = W'(x_ff == W'(1) && y_ff == W'(1));
                  default: v_wdata = W'(x_ff == W'(1) || y_ff == W'(1));
               endcase
            end
            if (state_in == S_FIN && err_in == ST_OK) state_in = S_IDLE;
         end
         S_DIVW: begin
            v_waddr = vcnt_ff[PTR_W-1:0] - 1'b1;
            v_wdata = drsp.result;
            if (drsp.done) begin
               v_we = 1'b1; state_in = S_IDLE;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
            if (last_ff) begin
               if (err_ff == ST_OK && ocnt_ff != '0) begin
                  tok_in = OP_PAREN; cmd_in = CMD_OP; state_in = S_OPRD;
               end else begin
                  state_in = S_OUT;
                  if (err_ff == ST_OK) begin
                     v_raddr = '0;
                     if (vcnt_ff == '0) err_in = ST_UNDER;
                     else if (vcnt_ff > CNT_W'(1)) err_in = ST_LEFT;
                  end
               end
            end
         end
         S_OUT: begin
            if (!ovalid_ff || rsp_ready) begin
               ovalid_in = 1'b1;
               ost_in = err_ff;
               oans_in = (err_ff == ST_OK) ? v_rdata[31:0] : '0;
               vcnt_in = '0; ocnt_in = '0; err_in = ST_OK; last_in = 1'b0;
               state_in = S_IDLE;
            end
            v_raddr = '0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // returning from an applied operator: resume the token's loop
   state_type nxt;
   always_comb begin
      nxt = state_in;
      if ((state_ff == S_EXEC || state_ff == S_DIVW) && state_in == S_IDLE) begin
         if (tok_ff == OP_PAREN && cmd_ff == CMD_OP) nxt = S_FIN;
         else if (cmd_ff == CMD_RPAREN) nxt = S_TOKEN;
         else nxt = (ocnt_ff == '0) ? S_OPCHK : S_OPRD;
      end else if ((state_ff == S_EXEC || state_ff == S_DIVW) && state_in == S_FIN) begin
         nxt = S_FIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcnt_ff <= '0;
         ocnt_ff <= '0;
         err_ff <= ST_OK;
         ovalid_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= nxt;
         vcnt_ff <= vcnt_in;
         ocnt_ff <= ocnt_in;
         err_ff <= err_in;
         ovalid_ff <= ovalid_in;
         last_ff <= last_in;
      end
      cmd_ff <= cmd_in; tok_ff <= tok_in; cur_ff <= cur_in; num_ff <= num_in;
      x_ff <= x_in;
      y_ff <= y_in;
      oans_ff <= oans_in; ost_ff <= ost_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_answer = oans_ff;
   assign rsp_status = ost_ff;

`ifndef SYNTHESIS
   a_vcnt_bound: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= CNT_W'(STACK_DEPTH)) else $error("value count out of range");
   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= CNT_W'(STACK_DEPTH)) else $error("operator count out of range");
   a_rsp_ok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_answer == '0)
      else $error("answer nonzero on error");
   a_div_only_wait: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> state_ff == S_DIVW) else $error("divider done outside wait");
`endif

endmodule
